// ===== sv/lfd_pkg.sv =====
// ----------------------------------------------------------------------------
// lfd_pkg
// Shared types and codes for the length-prefixed frame deframer.
// ----------------------------------------------------------------------------
package lfd_pkg;

    localparam int BYTE_W    = 8;
    localparam int COUNT_W   = 25;
    localparam int PATTERN_W = 32;
    localparam int CFG_W     = 32;
    localparam int PADDR_W   = 3;

    typedef logic [BYTE_W-1:0]  t_byte;
    typedef logic [COUNT_W-1:0] t_count;
    typedef logic [1:0]         t_status;
    typedef logic [1:0]         t_phase;

    // parser phases; the unused code behaves as hunting
    localparam t_phase PH_HEADER  = 2'd0;
    localparam t_phase PH_PAYLOAD = 2'd1;
    localparam t_phase PH_HUNT    = 2'd2;

    // frame status codes
    localparam t_status ST_GOOD     = 2'd0;
    localparam t_status ST_EARLY    = 2'd1;
    localparam t_status ST_MISSING  = 2'd2;
    localparam t_status ST_OVERSIZE = 2'd3;

    // register index, taken from paddr[2]
    localparam logic REG_PATTERN = 1'b0;
    localparam logic REG_MAX_LEN = 1'b1;

    localparam logic [PATTERN_W-1:0] PATTERN_RST = 32'h0403_0201;
    localparam t_count               MAX_LEN_RST = 25'd8294400;

endpackage

// ===== sv/lfd_if.sv =====
// ----------------------------------------------------------------------------
// lfd_rx_if / lfd_frm_if
// Valid/ready channels for received bytes and for deframed results.
// ----------------------------------------------------------------------------
interface lfd_rx_if
    import lfd_pkg::*;
;
    logic  valid;
    logic  ready;
    t_byte rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface lfd_frm_if
    import lfd_pkg::*;
;
    logic    valid;
    logic    ready;
    t_byte   payload_byte;
    logic    frame_end;
    t_status frame_status;
    t_count  payload_count;

    modport source (output valid, output payload_byte, output frame_end,
                    output frame_status, output payload_count, input ready);
    modport sink   (input valid, input payload_byte, input frame_end,
                    input frame_status, input payload_count, output ready);
endinterface

// ===== sv/length_prefixed_frame_deframer_core.sv =====
// ----------------------------------------------------------------------------
// length_prefixed_frame_deframer_core
// Splits a byte stream of length-prefixed, delimiter-terminated frames into
// payload bytes and one end item with status per frame.
// ----------------------------------------------------------------------------
//  channel  dir  handshake       payload
//  i_rx     in   valid/ready     rx_byte
//  o_frm    out  valid/ready     payload_byte, frame_end, frame_status,
//                                payload_count
//  apb      in   psel/penable    paddr, pwdata -> prdata, pready
//
//  one byte per cycle unless a stalled result waits; each byte gives at most one registered result
//  config registers, parser state and output register are the only storage; no memory
//  i_rst_n is synchronous, active low, and restores the register defaults
//  a stalled result blocks new bytes only while it is still waiting
// ----------------------------------------------------------------------------
module length_prefixed_frame_deframer_core
    import lfd_pkg::*;
#(
    parameter int LENGTH_FIELD_BYTES = 8,
    parameter int DELIMITER_BYTES    = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    lfd_rx_if.sink             i_rx,
    lfd_frm_if.source          o_frm,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [CFG_W-1:0]   pwdata,
    output logic [CFG_W-1:0]   prdata,
    output logic               pready
);

    localparam int LEN_W   = 8 * LENGTH_FIELD_BYTES;
    localparam int WIN_W   = 8 * DELIMITER_BYTES;
    localparam int PAT_W   = (WIN_W > PATTERN_W) ? WIN_W : PATTERN_W;
    localparam int HIW     = $clog2(LENGTH_FIELD_BYTES + DELIMITER_BYTES);
    localparam int WFW     = (DELIMITER_BYTES > 1) ? $clog2(DELIMITER_BYTES) : 1;
    localparam logic [HIW-1:0] HDR_LAST = HIW'(LENGTH_FIELD_BYTES + DELIMITER_BYTES - 1);
    localparam logic [WFW-1:0] FILL_MAX = WFW'(DELIMITER_BYTES - 1);

    // configuration
    logic [PATTERN_W-1:0] r_pattern;
    t_count               r_max_len;
    logic                 cfg_wr;

    // parser state
    t_phase           r_phase,  n_phase;
    logic [HIW-1:0]   r_idx,    n_idx;
    logic [LEN_W-1:0] r_len,    n_len;
    t_count           r_cnt,    n_cnt;
    logic [WIN_W-1:0] r_win,    n_win;
    logic [WFW-1:0]   r_fill,   n_fill;

    // result of the current byte
    logic    res_valid;
    t_byte   res_byte;
    logic    res_end;
    t_status res_status;
    t_count  res_count;

    // output register
    logic    r_ovalid;
    t_byte   r_obyte;
    logic    r_oend;
    t_status r_ostatus;
    t_count  r_ocount;

    logic             take;
    logic [WIN_W-1:0] cand;
    logic [PAT_W-1:0] pat_ext;
    logic             full;
    logic             match;

    // ------------------------------------------------------------------
    // apb register port
    // ------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern <= PATTERN_RST;
            r_max_len <= MAX_LEN_RST;
        end else if (cfg_wr) begin
            case (paddr[2])
                REG_PATTERN: r_pattern <= pwdata;
                REG_MAX_LEN: r_max_len <= pwdata[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_PATTERN: prdata = r_pattern;
            REG_MAX_LEN: prdata = CFG_W'(r_max_len);
            default:     prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // byte parser
    // ------------------------------------------------------------------
    assign i_rx.ready = !r_ovalid || o_frm.ready;
    assign take       = i_rx.valid && i_rx.ready;

    assign cand    = r_win | (WIN_W'(i_rx.rx_byte) << {r_fill, 3'b000});
    assign pat_ext = PAT_W'(r_pattern);
    assign full    = (r_fill >= FILL_MAX);
    assign match   = full && (cand == pat_ext[WIN_W-1:0]);

    always_comb begin
        n_phase    = r_phase;
        n_idx      = r_idx;
        n_len      = r_len;
        n_cnt      = r_cnt;
        n_win      = r_win;
        n_fill     = r_fill;
        res_valid  = 1'b0;
        res_byte   = '0;
        res_end    = 1'b0;
        res_status = ST_GOOD;
        res_count  = '0;

        if (take) begin
            case (r_phase)
                PH_HEADER: begin
                    // length bytes land in place; the skipped delimiter bytes do not
                    for (int k = 0; k < LENGTH_FIELD_BYTES; k++) begin
                        if (r_idx == HIW'(k)) begin
                            n_len[8*k +: 8] = i_rx.rx_byte;
                        end
                    end
                    if (r_idx == HDR_LAST) begin
                        n_idx  = '0;
                        n_cnt  = '0;
                        n_win  = '0;
                        n_fill = '0;
                        if (64'(r_len) > 64'(r_max_len)) begin
                            n_phase    = PH_HUNT;
                            res_valid  = 1'b1;
                            res_end    = 1'b1;
                            res_status = ST_OVERSIZE;
                        end else begin
                            n_phase = PH_PAYLOAD;
                        end
                    end else begin
                        n_idx = HIW'(r_idx + 1'b1);
                    end
                end
                PH_PAYLOAD: begin
                    if (match) begin
                        n_phase    = PH_HEADER;
                        n_idx      = '0;
                        n_win      = '0;
                        n_fill     = '0;
                        n_cnt      = '0;
                        res_valid  = 1'b1;
                        res_end    = 1'b1;
                        res_status = (64'(r_cnt) == 64'(r_len)) ? ST_GOOD : ST_EARLY;
                        res_count  = r_cnt;
                    end else if (!full) begin
                        n_win  = cand;
                        n_fill = WFW'(r_fill + 1'b1);
                    end else begin
                        n_win = cand >> 8;
                        if (64'(r_cnt) >= 64'(r_len)) begin
                            n_phase    = PH_HUNT;
                            n_cnt      = '0;
                            res_valid  = 1'b1;
                            res_end    = 1'b1;
                            res_status = ST_MISSING;
                            res_count  = r_cnt;
                        end else begin
                            // oldest held byte leaves the window as payload
                            n_cnt     = t_count'(r_cnt + 1'b1);
                            res_valid = 1'b1;
                            res_byte  = cand[7:0];
                        end
                    end
                end
                default: begin
                    // hunting: drop bytes until the delimiter shows up
                    if (match) begin
                        n_phase = PH_HEADER;
                        n_idx   = '0;
                        n_win   = '0;
                        n_fill  = '0;
                    end else if (!full) begin
                        n_win  = cand;
                        n_fill = WFW'(r_fill + 1'b1);
                    end else begin
                        n_win = cand >> 8;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HEADER;
            r_idx   <= '0;
            r_len   <= '0;
            r_cnt   <= '0;
            r_win   <= '0;
            r_fill  <= '0;
        end else begin
            r_phase <= n_phase;
            r_idx   <= n_idx;
            r_len   <= n_len;
            r_cnt   <= n_cnt;
            r_win   <= n_win;
            r_fill  <= n_fill;
        end
    end

    // ------------------------------------------------------------------
    // output register
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (take) begin
            r_ovalid <= res_valid;
        end else if (o_frm.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take && res_valid) begin
            r_obyte   <= res_byte;
            r_oend    <= res_end;
            r_ostatus <= res_status;
            r_ocount  <= res_count;
        end
    end

    assign o_frm.valid         = r_ovalid;
    assign o_frm.payload_byte  = r_obyte;
    assign o_frm.frame_end     = r_oend;
    assign o_frm.frame_status  = r_ostatus;
    assign o_frm.payload_count = r_ocount;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FILL_MAX)
        else $error("match window holds too many bytes");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_PAYLOAD) |-> (64'(r_cnt) <= 64'(r_len)))
        else $error("payload count ran past announced length");

    a_good_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_oend && (r_ostatus == ST_GOOD))
            |-> (64'(r_ocount) == 64'(r_len)))
        else $error("good frame count differs from announced length");

    a_oversize_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_oend && (r_ostatus == ST_OVERSIZE)) |-> (r_ocount == '0))
        else $error("oversize end item carries a nonzero count");

    a_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && !o_frm.ready) |=> (r_ovalid && $stable(r_ocount)))
        else $error("stalled result lost or changed");

endmodule
